FILE: design/lrs_pkg.sv
// Shared types and constants for the link recovery supervisor.
// Holds the register map, reset values and the word and result structures.
// No dependencies.
package lrs_pkg;

    localparam int TimeW  = 32;
    localparam int CountW = 8;
    localparam int AddrW  = 5;
    localparam int DataW  = 32;

    localparam logic [2:0] RegLossDebounce   = 3'd0;
    localparam logic [2:0] RegReconnectIntvl = 3'd1;
    localparam logic [2:0] RegLinkReboot     = 3'd2;
    localparam logic [2:0] RegStable         = 3'd3;
    localparam logic [2:0] RegRecoveryAfter  = 3'd4;
    localparam logic [2:0] RegCooldown       = 3'd5;
    localparam logic [2:0] RegMaxSoft        = 3'd6;
    localparam logic [2:0] RegNotreadyReboot = 3'd7;

    localparam logic [TimeW-1:0]  RstLossDebounce   = 32'd12000;
    localparam logic [TimeW-1:0]  RstReconnectIntvl = 32'd5000;
    localparam logic [TimeW-1:0]  RstLinkReboot     = 32'd900000;
    localparam logic [TimeW-1:0]  RstStable         = 32'd3000;
    localparam logic [TimeW-1:0]  RstRecoveryAfter  = 32'd45000;
    localparam logic [TimeW-1:0]  RstCooldown       = 32'd30000;
    localparam logic [CountW-1:0] RstMaxSoft        = 8'd12;
    localparam logic [TimeW-1:0]  RstNotreadyReboot = 32'd900000;

    localparam logic [CountW-1:0] CountMax = 8'hFF;

    typedef struct packed {
        logic [TimeW-1:0]  loss_debounce_ms;
        logic [TimeW-1:0]  reconnect_interval_ms;
        logic [TimeW-1:0]  link_reboot_ms;
        logic [TimeW-1:0]  stable_ms;
        logic [TimeW-1:0]  recovery_after_ms;
        logic [TimeW-1:0]  cooldown_ms;
        logic [CountW-1:0] max_soft_restarts;
        logic [TimeW-1:0]  notready_reboot_ms;
    } cfg_t;

    typedef struct packed {
        logic [TimeW-1:0] now_ms;
        logic             link_up;
        logic             tunnel_ready;
        logic             tunnel_busy;
    } poll_t;

    typedef struct packed {
        logic              stop_tunnel;
        logic              start_tunnel;
        logic              request_reconnect;
        logic              request_reboot;
        logic              publish_address;
        logic [CountW-1:0] restart_count;
    } result_t;

endpackage

FILE: design/lrs_cfg.sv
// Configuration register file of the link recovery supervisor.
// Decodes APB-style writes and reads; depends on lrs_pkg.
module lrs_cfg
    import lrs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output cfg_t             cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.loss_debounce_ms      <= RstLossDebounce;
            cfg_reg.reconnect_interval_ms <= RstReconnectIntvl;
            cfg_reg.link_reboot_ms        <= RstLinkReboot;
            cfg_reg.stable_ms             <= RstStable;
            cfg_reg.recovery_after_ms     <= RstRecoveryAfter;
            cfg_reg.cooldown_ms           <= RstCooldown;
            cfg_reg.max_soft_restarts     <= RstMaxSoft;
            cfg_reg.notready_reboot_ms    <= RstNotreadyReboot;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                RegLossDebounce:   cfg_reg.loss_debounce_ms      <= pwdata;
                RegReconnectIntvl: cfg_reg.reconnect_interval_ms <= pwdata;
                RegLinkReboot:     cfg_reg.link_reboot_ms        <= pwdata;
                RegStable:         cfg_reg.stable_ms             <= pwdata;
                RegRecoveryAfter:  cfg_reg.recovery_after_ms     <= pwdata;
                RegCooldown:       cfg_reg.cooldown_ms           <= pwdata;
                RegMaxSoft:        cfg_reg.max_soft_restarts     <= pwdata[CountW-1:0];
                RegNotreadyReboot: cfg_reg.notready_reboot_ms    <= pwdata;
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            RegLossDebounce:   prdata = cfg_reg.loss_debounce_ms;
            RegReconnectIntvl: prdata = cfg_reg.reconnect_interval_ms;
            RegLinkReboot:     prdata = cfg_reg.link_reboot_ms;
            RegStable:         prdata = cfg_reg.stable_ms;
            RegRecoveryAfter:  prdata = cfg_reg.recovery_after_ms;
            RegCooldown:       prdata = cfg_reg.cooldown_ms;
            RegMaxSoft:        prdata = {{(DataW-CountW){1'b0}}, cfg_reg.max_soft_restarts};
            RegNotreadyReboot: prdata = cfg_reg.notready_reboot_ms;
            default:           prdata = '0;
        endcase
    end

endmodule

FILE: design/lrs_core.sv
// Supervisor state and the decision logic for one poll word.
// Updates the timers and counters when a word moves on; depends on lrs_pkg.
module lrs_core
    import lrs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  poll_t   poll,
    input  cfg_t    cfg,
    output result_t res
);

    logic [TimeW-1:0]  lost_since_reg, lost_since_next;
    logic              lost_valid_reg, lost_valid_next;
    logic [TimeW-1:0]  up_since_reg, up_since_next;
    logic              up_valid_reg, up_valid_next;
    logic [TimeW-1:0]  notready_since_reg, notready_since_next;
    logic              notready_valid_reg, notready_valid_next;
    logic [TimeW-1:0]  last_soft_reg, last_soft_next;
    logic              soft_valid_reg, soft_valid_next;
    logic [TimeW-1:0]  last_reconnect_reg, last_reconnect_next;
    logic              was_ready_reg, was_ready_next;
    logic              stopped_reg, stopped_next;
    logic [CountW-1:0] soft_count_reg, soft_count_next;

    logic [TimeW-1:0]  down_ms;
    logic [TimeW-1:0]  waited_ms;
    logic              stop_c, start_c, recon_c, reboot_c, publish_c;

    always_comb
    begin
        lost_since_next     = lost_since_reg;
        lost_valid_next     = lost_valid_reg;
        up_since_next       = up_since_reg;
        up_valid_next       = up_valid_reg;
        notready_since_next = notready_since_reg;
        notready_valid_next = notready_valid_reg;
        last_soft_next      = last_soft_reg;
        soft_valid_next     = soft_valid_reg;
        last_reconnect_next = last_reconnect_reg;
        was_ready_next      = was_ready_reg;
        stopped_next        = stopped_reg;
        soft_count_next     = soft_count_reg;
        down_ms             = '0;
        waited_ms           = '0;
        stop_c              = 1'b0;
        start_c             = 1'b0;
        recon_c             = 1'b0;
        reboot_c            = 1'b0;
        publish_c           = 1'b0;

        // Link handling.
        if (!poll.link_up)
        begin
            up_valid_next = 1'b0;
            up_since_next = '0;
            if (!lost_valid_reg)
            begin
                lost_valid_next = 1'b1;
                lost_since_next = poll.now_ms;
            end
            notready_valid_next = 1'b0;
            notready_since_next = '0;
            soft_valid_next     = 1'b0;
            last_soft_next      = '0;
            soft_count_next     = '0;
            down_ms = poll.now_ms - lost_since_next;
            if (down_ms > cfg.loss_debounce_ms)
            begin
                if (!stopped_reg)
                begin
                    stopped_next   = 1'b1;
                    was_ready_next = 1'b0;
                    stop_c         = 1'b1;
                end
                if ((poll.now_ms - last_reconnect_reg) > cfg.reconnect_interval_ms)
                begin
                    last_reconnect_next = poll.now_ms;
                    recon_c             = 1'b1;
                end
                if (down_ms >= cfg.link_reboot_ms)
                begin
                    reboot_c = 1'b1;
                end
            end
        end
        else if (stopped_reg)
        begin
            lost_valid_next = 1'b0;
            lost_since_next = '0;
            if (!up_valid_reg)
            begin
                up_valid_next = 1'b1;
                up_since_next = poll.now_ms;
            end
            else if ((poll.now_ms - up_since_reg) > cfg.stable_ms)
            begin
                stopped_next = 1'b0;
                start_c      = 1'b1;
            end
        end
        else
        begin
            lost_valid_next = 1'b0;
            lost_since_next = '0;
        end

        // Tunnel readiness handling.
        if (poll.tunnel_ready)
        begin
            notready_valid_next = 1'b0;
            notready_since_next = '0;
            soft_valid_next     = 1'b0;
            last_soft_next      = '0;
            soft_count_next     = '0;
            if (!was_ready_next)
            begin
                publish_c      = 1'b1;
                was_ready_next = 1'b1;
            end
        end
        else
        begin
            was_ready_next = 1'b0;
            if (!poll.link_up || stopped_next)
            begin
                notready_valid_next = 1'b0;
                notready_since_next = '0;
                soft_valid_next     = 1'b0;
                last_soft_next      = '0;
                soft_count_next     = '0;
            end
            else
            begin
                if (!notready_valid_reg)
                begin
                    notready_valid_next = 1'b1;
                    notready_since_next = poll.now_ms;
                end
                waited_ms = poll.now_ms - notready_since_next;
                if ((waited_ms >= cfg.recovery_after_ms) &&
                    (!soft_valid_reg ||
                     ((poll.now_ms - last_soft_reg) >= cfg.cooldown_ms)) &&
                    !poll.tunnel_busy)
                begin
                    if (soft_count_reg != CountMax)
                    begin
                        soft_count_next = soft_count_reg + 1'b1;
                    end
                    last_soft_next  = poll.now_ms;
                    soft_valid_next = 1'b1;
                    stop_c          = 1'b1;
                    start_c         = 1'b1;
                end
                if ((waited_ms >= cfg.notready_reboot_ms) ||
                    (soft_count_next >= cfg.max_soft_restarts))
                begin
                    reboot_c = 1'b1;
                end
            end
        end
    end

    assign res.stop_tunnel       = stop_c;
    assign res.start_tunnel      = start_c;
    assign res.request_reconnect = recon_c;
    assign res.request_reboot    = reboot_c;
    assign res.publish_address   = publish_c;
    assign res.restart_count     = soft_count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lost_since_reg     <= '0;
            lost_valid_reg     <= 1'b0;
            up_since_reg       <= '0;
            up_valid_reg       <= 1'b0;
            notready_since_reg <= '0;
            notready_valid_reg <= 1'b0;
            last_soft_reg      <= '0;
            soft_valid_reg     <= 1'b0;
            last_reconnect_reg <= '0;
            was_ready_reg      <= 1'b0;
            stopped_reg        <= 1'b0;
            soft_count_reg     <= '0;
        end
        else if (step)
        begin
            lost_since_reg     <= lost_since_next;
            lost_valid_reg     <= lost_valid_next;
            up_since_reg       <= up_since_next;
            up_valid_reg       <= up_valid_next;
            notready_since_reg <= notready_since_next;
            notready_valid_reg <= notready_valid_next;
            last_soft_reg      <= last_soft_next;
            soft_valid_reg     <= soft_valid_next;
            last_reconnect_reg <= last_reconnect_next;
            was_ready_reg      <= was_ready_next;
            stopped_reg        <= stopped_next;
            soft_count_reg     <= soft_count_next;
        end
    end

endmodule

FILE: design/link_recovery_supervisor.sv
// Top level of the link recovery supervisor: input and output word registers.
// Instantiates lrs_cfg and lrs_core; depends on lrs_pkg.
//
// Each poll word is captured in an input register, evaluated against the
// supervisor state by combinational logic and written to an output register;
// it is held in the input register only while the output is stalled, and a
// new word may be accepted on every cycle unless a stalled result blocks it.
// The only loop is the supervisor state itself, which is updated in the same
// cycle that a word moves into the output register. Configuration registers
// should be written only when no words are in flight.
module link_recovery_supervisor
    import lrs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [AddrW-1:0]  paddr,
    input  logic [DataW-1:0]  pwdata,
    output logic [DataW-1:0]  prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [TimeW-1:0]  now_ms,
    input  logic              link_up,
    input  logic              tunnel_ready,
    input  logic              tunnel_busy,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              stop_tunnel,
    output logic              start_tunnel,
    output logic              request_reconnect,
    output logic              request_reboot,
    output logic              publish_address,
    output logic [CountW-1:0] restart_count
);

    cfg_t    cfg;
    poll_t   poll_reg;
    logic    in_valid_reg;
    result_t res_c;
    result_t res_reg;
    logic    out_valid_reg;
    logic    advance;
    logic    in_take;

    assign pready   = 1'b1;
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    lrs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    lrs_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .poll  (poll_reg),
        .cfg   (cfg),
        .res   (res_c)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            poll_reg.now_ms       <= now_ms;
            poll_reg.link_up      <= link_up;
            poll_reg.tunnel_ready <= tunnel_ready;
            poll_reg.tunnel_busy  <= tunnel_busy;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_c;
        end
    end

    assign out_valid         = out_valid_reg;
    assign stop_tunnel       = res_reg.stop_tunnel;
    assign start_tunnel      = res_reg.start_tunnel;
    assign request_reconnect = res_reg.request_reconnect;
    assign request_reboot    = res_reg.request_reboot;
    assign publish_address   = res_reg.publish_address;
    assign restart_count     = res_reg.restart_count;

`ifndef SYNTHESIS
    // A reconnect request only comes while the link is down, a start never does.
    a_recon_no_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(res_reg.request_reconnect && res_reg.start_tunnel))
        else $error("reconnect and start raised in the same word");

    // A ready tunnel clears the recovery state, so a publish shows a zero count.
    a_publish_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.publish_address) |-> (res_reg.restart_count == '0))
        else $error("publish with a non-zero restart count");

    // A result appears only after a word has left the input register.
    a_out_from_in: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("result appeared without an input word");
`endif

endmodule

FILE: tb/sv/tb_link_recovery_supervisor.sv
// Self-checking testbench for the link recovery supervisor.
// Drives poll words and register writes, predicts every result word and compares it.
// Depends on lrs_pkg and link_recovery_supervisor.
module tb_link_recovery_supervisor;
    import lrs_pkg::*;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [AddrW-1:0]  paddr = '0;
    logic [DataW-1:0]  pwdata = '0;
    logic [DataW-1:0]  prdata;
    logic              pready;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [TimeW-1:0]  now_ms = '0;
    logic              link_up = 1'b0;
    logic              tunnel_ready = 1'b0;
    logic              tunnel_busy = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              stop_tunnel;
    logic              start_tunnel;
    logic              request_reconnect;
    logic              request_reboot;
    logic              publish_address;
    logic [CountW-1:0] restart_count;

    link_recovery_supervisor uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .now_ms            (now_ms),
        .link_up           (link_up),
        .tunnel_ready      (tunnel_ready),
        .tunnel_busy       (tunnel_busy),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .stop_tunnel       (stop_tunnel),
        .start_tunnel      (start_tunnel),
        .request_reconnect (request_reconnect),
        .request_reboot    (request_reboot),
        .publish_address   (publish_address),
        .restart_count     (restart_count)
    );

    cfg_t              cfg_model;
    result_t           expected_results[$];
    int                mismatches = 0;
    bit                quiet = 1'b0;
    bit                hold_req = 1'b0;

    logic [TimeW-1:0]  lost_at;
    logic              lost_seen;
    logic [TimeW-1:0]  up_at;
    logic              up_seen;
    logic [TimeW-1:0]  notready_at;
    logic              notready_seen;
    logic [TimeW-1:0]  last_restart_at;
    logic              restart_seen;
    logic [TimeW-1:0]  reconnect_at;
    logic              ready_seen;
    logic              link_stopped;
    logic [CountW-1:0] restarts;

    logic [TimeW-1:0]  scen_time;
    logic              scen_link;
    logic              scen_ready;

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
        mismatches++;
    endtask

    task automatic clear_restart_state();
        notready_seen   = 1'b0;
        notready_at     = '0;
        restart_seen    = 1'b0;
        last_restart_at = '0;
        restarts        = '0;
    endtask

    task automatic reset_supervisor_model();
        cfg_model.loss_debounce_ms      = RstLossDebounce;
        cfg_model.reconnect_interval_ms = RstReconnectIntvl;
        cfg_model.link_reboot_ms        = RstLinkReboot;
        cfg_model.stable_ms             = RstStable;
        cfg_model.recovery_after_ms     = RstRecoveryAfter;
        cfg_model.cooldown_ms           = RstCooldown;
        cfg_model.max_soft_restarts     = RstMaxSoft;
        cfg_model.notready_reboot_ms    = RstNotreadyReboot;
        lost_at      = '0;
        lost_seen    = 1'b0;
        up_at        = '0;
        up_seen      = 1'b0;
        reconnect_at = '0;
        ready_seen   = 1'b0;
        link_stopped = 1'b0;
        clear_restart_state();
    endtask

    task automatic supervise(input poll_t p, output result_t r);
        logic [TimeW-1:0] down;
        logic [TimeW-1:0] since_reconnect;
        logic [TimeW-1:0] up_for;
        logic [TimeW-1:0] waited;
        logic [TimeW-1:0] since_restart;
        r = '0;
        if (!p.link_up)
        begin
            up_seen = 1'b0;
            up_at   = '0;
            if (!lost_seen)
            begin
                lost_seen = 1'b1;
                lost_at   = p.now_ms;
            end
            clear_restart_state();
            down = p.now_ms - lost_at;
            if (down > cfg_model.loss_debounce_ms)
            begin
                if (!link_stopped)
                begin
                    link_stopped  = 1'b1;
                    ready_seen    = 1'b0;
                    r.stop_tunnel = 1'b1;
                end
                since_reconnect = p.now_ms - reconnect_at;
                if (since_reconnect > cfg_model.reconnect_interval_ms)
                begin
                    reconnect_at        = p.now_ms;
                    r.request_reconnect = 1'b1;
                end
                if (down >= cfg_model.link_reboot_ms)
                    r.request_reboot = 1'b1;
            end
        end
        else if (link_stopped)
        begin
            lost_seen = 1'b0;
            lost_at   = '0;
            up_for    = p.now_ms - up_at;
            if (!up_seen)
            begin
                up_seen = 1'b1;
                up_at   = p.now_ms;
            end
            else if (up_for > cfg_model.stable_ms)
            begin
                link_stopped   = 1'b0;
                r.start_tunnel = 1'b1;
            end
        end
        else
        begin
            lost_seen = 1'b0;
            lost_at   = '0;
        end

        if (p.tunnel_ready)
        begin
            clear_restart_state();
            if (!ready_seen)
            begin
                r.publish_address = 1'b1;
                ready_seen        = 1'b1;
            end
        end
        else
        begin
            ready_seen = 1'b0;
            if (!p.link_up || link_stopped)
                clear_restart_state();
            else
            begin
                if (!notready_seen)
                begin
                    notready_seen = 1'b1;
                    notready_at   = p.now_ms;
                end
                waited        = p.now_ms - notready_at;
                since_restart = p.now_ms - last_restart_at;
                if (waited >= cfg_model.recovery_after_ms &&
                    (!restart_seen || since_restart >= cfg_model.cooldown_ms) &&
                    !p.tunnel_busy)
                begin
                    if (restarts != CountMax)
                        restarts = restarts + 1'b1;
                    last_restart_at = p.now_ms;
                    restart_seen    = 1'b1;
                    r.stop_tunnel   = 1'b1;
                    r.start_tunnel  = 1'b1;
                end
                if (waited >= cfg_model.notready_reboot_ms ||
                    restarts >= cfg_model.max_soft_restarts)
                    r.request_reboot = 1'b1;
            end
        end
        r.restart_count = restarts;
    endtask

    function automatic int pick_idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 10);
        return $urandom_range(15, 50);
    endfunction

    task automatic send_poll(input logic [TimeW-1:0] t, input logic link,
                             input logic ready, input logic busy);
        int      gap;
        poll_t   p;
        result_t r;
        gap = (!quiet && $urandom_range(0, 1) == 0) ? pick_idle_len() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        now_ms       <= t;
        link_up      <= link;
        tunnel_ready <= ready;
        tunnel_busy  <= busy;
        do
            @(posedge clk);
        while (in_stall);
        p.now_ms       = t;
        p.link_up      = link;
        p.tunnel_ready = ready;
        p.tunnel_busy  = busy;
        supervise(p, r);
        expected_results.push_back(r);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    function automatic logic [AddrW-1:0] reg_addr(input logic [2:0] idx);
        return {idx, 2'b00};
    endfunction

    function automatic logic [DataW-1:0] reg_value(input logic [2:0] idx);
        case (idx)
            RegLossDebounce:   return cfg_model.loss_debounce_ms;
            RegReconnectIntvl: return cfg_model.reconnect_interval_ms;
            RegLinkReboot:     return cfg_model.link_reboot_ms;
            RegStable:         return cfg_model.stable_ms;
            RegRecoveryAfter:  return cfg_model.recovery_after_ms;
            RegCooldown:       return cfg_model.cooldown_ms;
            RegMaxSoft:        return {24'd0, cfg_model.max_soft_restarts};
            default:           return cfg_model.notready_reboot_ms;
        endcase
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [DataW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= reg_addr(idx);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            RegLossDebounce:   cfg_model.loss_debounce_ms      = value;
            RegReconnectIntvl: cfg_model.reconnect_interval_ms = value;
            RegLinkReboot:     cfg_model.link_reboot_ms        = value;
            RegStable:         cfg_model.stable_ms             = value;
            RegRecoveryAfter:  cfg_model.recovery_after_ms     = value;
            RegCooldown:       cfg_model.cooldown_ms           = value;
            RegMaxSoft:        cfg_model.max_soft_restarts     = value[CountW-1:0];
            default:           cfg_model.notready_reboot_ms    = value;
        endcase
        @(posedge clk);
    endtask

    task automatic check_reg(input logic [2:0] idx);
        logic [DataW-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= reg_addr(idx);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== reg_value(idx))
            report_mismatch($sformatf("register %0d read", idx), got, reg_value(idx));
        @(posedge clk);
    endtask

    task automatic set_config(input cfg_t c);
        logic [23:0] junk;
        junk = 24'($urandom);
        write_reg(RegLossDebounce, c.loss_debounce_ms);
        write_reg(RegReconnectIntvl, c.reconnect_interval_ms);
        write_reg(RegLinkReboot, c.link_reboot_ms);
        write_reg(RegStable, c.stable_ms);
        write_reg(RegRecoveryAfter, c.recovery_after_ms);
        write_reg(RegCooldown, c.cooldown_ms);
        write_reg(RegMaxSoft, {junk, c.max_soft_restarts});
        write_reg(RegNotreadyReboot, c.notready_reboot_ms);
    endtask

    function automatic logic [TimeW-1:0] random_interval();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        else if (r == 1)
            return ($urandom_range(0, 1) == 0) ? '1 : TimeW'($urandom);
        return $urandom_range(1, 40);
    endfunction

    function automatic cfg_t random_config();
        cfg_t c;
        c.loss_debounce_ms      = random_interval();
        c.reconnect_interval_ms = random_interval();
        c.link_reboot_ms        = random_interval();
        c.stable_ms             = random_interval();
        c.recovery_after_ms     = random_interval();
        c.cooldown_ms           = random_interval();
        c.notready_reboot_ms    = random_interval();
        case ($urandom_range(0, 9))
            0:       c.max_soft_restarts = '0;
            1:       c.max_soft_restarts = CountMax;
            default: c.max_soft_restarts = CountW'($urandom_range(1, 8));
        endcase
        return c;
    endfunction

    task automatic run_random_polls(input int count);
        int r;
        repeat (count)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                send_poll($urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            end
            else
            begin
                if ($urandom_range(0, 24) == 0)
                    scen_link = ~scen_link;
                if ($urandom_range(0, 11) == 0)
                    scen_ready = ~scen_ready;
                if ($urandom_range(0, 39) == 0)
                    scen_time = scen_time + TimeW'($urandom_range(0, 2000));
                else
                    scen_time = scen_time + TimeW'($urandom_range(0, 12));
                send_poll(scen_time, scen_link, scen_ready, $urandom_range(0, 3) == 0);
            end
        end
    endtask

    task automatic test_register_access();
        for (int i = 0; i < 8; i++)
            check_reg(3'(i));
        set_config(random_config());
        for (int i = 0; i < 8; i++)
            check_reg(3'(i));
        write_reg(RegLossDebounce, RstLossDebounce);
        write_reg(RegReconnectIntvl, RstReconnectIntvl);
        write_reg(RegLinkReboot, RstLinkReboot);
        write_reg(RegStable, RstStable);
        write_reg(RegRecoveryAfter, RstRecoveryAfter);
        write_reg(RegCooldown, RstCooldown);
        write_reg(RegMaxSoft, {24'd0, RstMaxSoft});
        write_reg(RegNotreadyReboot, RstNotreadyReboot);
    endtask

    task automatic test_directed_recovery();
        send_poll(32'd1000, 1'b1, 1'b1, 1'b0);
        send_poll(32'd2000, 1'b1, 1'b0, 1'b0);
        send_poll(32'd47000, 1'b1, 1'b0, 1'b1);
        send_poll(32'd47001, 1'b1, 1'b0, 1'b0);
        send_poll(32'd60000, 1'b1, 1'b0, 1'b0);
        send_poll(32'd77001, 1'b1, 1'b0, 1'b0);
        send_poll(32'd78000, 1'b1, 1'b1, 1'b0);
        send_poll(32'd80000, 1'b0, 1'b0, 1'b0);
        send_poll(32'd92000, 1'b0, 1'b0, 1'b0);
        send_poll(32'd92001, 1'b0, 1'b0, 1'b1);
        send_poll(32'd95000, 1'b0, 1'b0, 1'b0);
        send_poll(32'd97002, 1'b0, 1'b0, 1'b0);
        send_poll(32'd99000, 1'b0, 1'b1, 1'b0);
        send_poll(32'd99500, 1'b0, 1'b0, 1'b0);
        send_poll(32'd980000, 1'b0, 1'b0, 1'b0);
        send_poll(32'd980100, 1'b1, 1'b1, 1'b0);
        send_poll(32'd983100, 1'b1, 1'b1, 1'b0);
        send_poll(32'd983101, 1'b1, 1'b1, 1'b0);
        send_poll(32'd983200, 1'b1, 1'b0, 1'b0);
        send_poll(32'd1883200, 1'b1, 1'b0, 1'b1);
        send_poll(32'd1883300, 1'b1, 1'b0, 1'b0);
        wait_drained();
    endtask

    task automatic test_restart_saturation();
        logic [TimeW-1:0] t;
        cfg_t             c;
        c = cfg_model;
        c.stable_ms          = '0;
        c.recovery_after_ms  = '0;
        c.cooldown_ms        = '0;
        c.max_soft_restarts  = CountMax;
        c.notready_reboot_ms = '1;
        set_config(c);
        t = 32'd5000000;
        send_poll(t, 1'b1, 1'b1, 1'b0);
        repeat (262)
        begin
            t = t + 1;
            send_poll(t, 1'b1, 1'b0, 1'b0);
        end
        wait_drained();
        write_reg(RegMaxSoft, '0);
        send_poll(t + 1, 1'b1, 1'b1, 1'b0);
        send_poll(t + 2, 1'b1, 1'b0, 1'b1);
        send_poll(t + 3, 1'b1, 1'b0, 1'b0);
        wait_drained();
    endtask

    task automatic test_config_extremes();
        logic [TimeW-1:0] t;
        set_config('0);
        t = 32'd100;
        send_poll(t, 1'b1, 1'b0, 1'b0);
        send_poll(t, 1'b1, 1'b0, 1'b0);
        send_poll(t + 1, 1'b0, 1'b0, 1'b0);
        send_poll(t + 2, 1'b0, 1'b0, 1'b0);
        send_poll(t + 3, 1'b1, 1'b0, 1'b0);
        send_poll(t + 4, 1'b1, 1'b1, 1'b0);
        wait_drained();
        set_config('1);
        send_poll(32'hFFFF_FFF0, 1'b1, 1'b0, 1'b0);
        send_poll(32'h0000_0010, 1'b1, 1'b0, 1'b0);
        send_poll(32'h7FFF_FFFF, 1'b0, 1'b0, 1'b1);
        send_poll(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0);
        send_poll(32'h0000_0000, 1'b1, 1'b1, 1'b1);
        wait_drained();
    endtask

    task automatic test_random_polls();
        for (int phase = 0; phase < 5; phase++)
        begin
            set_config(random_config());
            scen_time  = (phase == 0) ? 32'hFFFF_FF00 : TimeW'($urandom);
            scen_link  = 1'($urandom_range(0, 1));
            scen_ready = 1'($urandom_range(0, 1));
            quiet      = (phase == 2);
            run_random_polls(230);
            quiet      = 1'b0;
            wait_drained();
        end
    endtask

    task automatic test_output_hold_off();
        cfg_t c;
        c = random_config();
        c.max_soft_restarts = CountW'($urandom_range(1, 8));
        set_config(c);
        quiet    = 1'b1;
        hold_req = 1'b1;
        run_random_polls(60);
        quiet = 1'b0;
        wait_drained();
    endtask

    initial
    begin
        reset_supervisor_model();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_register_access();
        test_directed_recovery();
        test_restart_saturation();
        test_config_extremes();
        test_random_polls();
        test_output_hold_off();
        wait_drained();
        repeat (5) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat (pick_idle_len()) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result word", 1, 0);
            else
            begin
                want = expected_results.pop_front();
                if (stop_tunnel !== want.stop_tunnel)
                    report_mismatch("stop_tunnel", 32'(stop_tunnel),
                                    32'(want.stop_tunnel));
                if (start_tunnel !== want.start_tunnel)
                    report_mismatch("start_tunnel", 32'(start_tunnel),
                                    32'(want.start_tunnel));
                if (request_reconnect !== want.request_reconnect)
                    report_mismatch("request_reconnect", 32'(request_reconnect),
                                    32'(want.request_reconnect));
                if (request_reboot !== want.request_reboot)
                    report_mismatch("request_reboot", 32'(request_reboot),
                                    32'(want.request_reboot));
                if (publish_address !== want.publish_address)
                    report_mismatch("publish_address", 32'(publish_address),
                                    32'(want.publish_address));
                if (restart_count !== want.restart_count)
                    report_mismatch("restart_count", 32'(restart_count),
                                    32'(want.restart_count));
            end
        end
    end

    initial
    begin
        #8000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
